// ===== hw/rtl/rr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rr_pkg;

  // Default datapath width
  localparam int WORD_WIDTH_DEF = 64;

  // Field widths on the ports
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 63;
  localparam int KIND_W    = 2;
  localparam int S_TDATA_W = 128;
  localparam int M_TDATA_W = 128;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_PROPER = 2'd0;
  localparam kind_t KIND_WHOLE  = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/rational_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Bits  Contents
// s_*      in   128   tdata: numerator_in [63:0], denominator_in [127:64]
// m_*      out  128   tdata: numerator_out [63:0], denominator_out [126:64]
//                     tuser: result_kind [1:0]
//
// Flow: one word at a time; a new word is taken only once the last result is in
//   the output register. A fraction runs k Euclid remainder steps (k up to about
//   1.44 * WORD_WIDTH), then divides |n| and |d| by the gcd; all of these run in the
//   single bit-serial divider. A zero denominator skips the divider and goes
//   straight to the output register.
// Reset: rst, synchronous, clears sequencer and output valid.
// Stalls: the result sits in the output register; the next word is taken
//   while it waits, and the sequencer holds before loading a new result.

module rational_reduce #(
  parameter int WORD_WIDTH = rr_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rr_pkg::S_TDATA_W-1:0]  s_tdata,   // numerator_in, denominator_in
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [rr_pkg::M_TDATA_W-1:0]  m_tdata,   // numerator_out, denominator_out, 0
  output logic      [rr_pkg::KIND_W-1:0]     m_tuser    // result_kind
);

  import rr_pkg::*;

  localparam int W = WORD_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOP = 3'd1;  // issue next remainder or first quotient
  localparam logic [2:0] ST_MODW = 3'd2;  // wait on a % b
  localparam logic [2:0] ST_DIVN = 3'd3;  // wait on |n| / g
  localparam logic [2:0] ST_DIVD = 3'd4;  // wait on |d| / g
  localparam logic [2:0] ST_OUT  = 3'd5;  // load output register

  localparam logic [W-1:0] TOP    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] TOP_M1 = ~TOP;

  logic [2:0]   state;
  logic [W-1:0] na, da;   // saturated magnitudes
  logic         nneg, dneg, err;
  logic [W-1:0] a, b;     // Euclid pair
  logic [W-1:0] rn, rd;

  // input term split
  logic [W-1:0] n_raw, d_raw, n_neg, d_neg, n_mag, d_mag;
  assign n_raw = s_tdata[W-1:0];
  assign d_raw = s_tdata[NUM_W +: W];
  assign n_neg = -n_raw;
  assign d_neg = -d_raw;
  assign n_mag = n_raw[W-1] ? ((n_neg == TOP) ? TOP_M1 : n_neg) : n_raw;
  assign d_mag = d_raw[W-1] ? ((d_neg == TOP) ? TOP_M1 : d_neg) : d_raw;

  // shared divider
  logic         div_start, div_done;
  logic [W-1:0] div_dvd, div_dvs, div_quo, div_rem;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = a;
    div_dvs   = b;
    case (state)
      ST_LOOP: begin
        div_start = 1'b1;
        if (b == '0) begin
          div_dvd = na;   // gcd found in a
          div_dvs = a;
        end
      end
      ST_DIVN: begin
        div_start = div_done;
        div_dvd   = da;
        div_dvs   = a;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rr_div #(
    .WORD_WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // result assembly
  logic signed [W-1:0] num_s;
  logic [NUM_W-1:0]    num_o;
  logic [DEN_W-1:0]    den_o;
  kind_t               kind_o;

  always_comb begin
    num_s = (rn != '0 && (nneg ^ dneg)) ? $signed(-rn) : $signed(rn);
    if (err) begin
      num_o  = '0;
      den_o  = '0;
      kind_o = KIND_ERROR;
    end else begin
      num_o  = NUM_W'(num_s);
      den_o  = DEN_W'(rd);
      kind_o = (rd == W'(1)) ? KIND_WHOLE : KIND_PROPER;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set on load, cleared when taken
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (d_mag == '0) ? ST_OUT : ST_LOOP;
          end
        end
        ST_LOOP: begin
          state <= (b == '0) ? ST_DIVN : ST_MODW;
        end
        ST_MODW: begin
          if (div_done) begin
            state <= ST_LOOP;
          end
        end
        ST_DIVN: begin
          if (div_done) begin
            state <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          na   <= n_mag;
          da   <= d_mag;
          a    <= n_mag;
          b    <= d_mag;
          nneg <= n_raw[W-1];
          dneg <= d_raw[W-1];
          err  <= (d_mag == '0);
        end
      end
      ST_MODW: begin
        if (div_done) begin
          a <= b;
          b <= div_rem;
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          rn <= div_quo;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          rd <= div_quo;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {1'b0, den_o, num_o};
          m_tuser <= kind_o;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_PROPER || m_tuser == KIND_WHOLE ||
                  m_tuser == KIND_ERROR))
    else $error("result kind out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tdata == '0))
    else $error("error result carries data");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_ERROR) |-> (m_tdata[NUM_W +: DEN_W] != '0))
    else $error("zero denominator on a valid fraction");

  a_whole_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_WHOLE) |-> (m_tdata[NUM_W +: DEN_W] == DEN_W'(1)))
    else $error("whole number with denominator other than one");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODW && !div_done) |-> !div_start)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/rr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rr_div #(
  parameter int WORD_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [WORD_WIDTH-1:0] dividend,
  input  wire logic [WORD_WIDTH-1:0] divisor,
  output logic                       done,
  output logic      [WORD_WIDTH-1:0] quo,
  output logic      [WORD_WIDTH-1:0] rem
);

  import rr_pkg::*;

  localparam int CNT_W = $clog2(WORD_WIDTH + 1);

  logic [CNT_W-1:0]      cnt;
  logic [WORD_WIDTH-1:0] dvs;
  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH:0]   diff;

  assign shifted = {rem, quo[WORD_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(WORD_WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      // borrow clear: subtract succeeds, quotient bit set
      rem <= diff[WORD_WIDTH] ? shifted[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
      quo <= {quo[WORD_WIDTH-2:0], ~diff[WORD_WIDTH]};
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rr_pkg::*;

  // Datapath width of the instance; the predictor follows it.
  localparam int WW = WORD_WIDTH_DEF;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  // Two consecutive Fibonacci numbers: the longest Euclid chain for signed 64-bit terms.
  localparam logic [63:0] FIB_91 = 64'd4660046610375530309;
  localparam logic [63:0] FIB_92 = 64'd7540113804746346429;

  // Random idling stops once this few fractions remain to be sent.
  localparam int TAIL_ITEMS = 120;
  // Drain window after the last result.
  localparam int DRAIN_CYCLES = 7000;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } fraction_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    kind_t            kind;
  } reduced_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // numerator_in [63:0], denominator_in [127:64]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // numerator_out [63:0], denominator_out [126:64], 0
  logic [KIND_W-1:0]    m_tuser;   // result_kind [1:0]

  fraction_t pending[$];     // fractions still to be driven
  reduced_t  reduced_q[$];   // predicted results in order of acceptance
  reduced_t  want;

  int  n_total;
  int  n_fed;
  int  n_errors;
  int  in_gap;
  int  out_gap;
  logic in_fire;             // input word taken at the last rising edge

  rational_reduce #(
    .WORD_WIDTH(WW)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude of a raw term at WW bits; the most negative value saturates
  // so that negation can never overflow.
  function automatic logic [63:0] term_magnitude(input logic [63:0] raw, output logic neg);
    logic [63:0] mask;
    logic [63:0] top;
    logic [63:0] v;
    logic [63:0] mag;
    mask = {64{1'b1}} >> (64 - WW);
    top  = 64'd1 << (WW - 1);
    v    = raw & mask;
    neg  = (v & top) != 64'd0;
    if (neg) begin
      mag = (~v + 64'd1) & mask;
      if (mag == top) mag = top - 64'd1;
    end else begin
      mag = v;
    end
    return mag;
  endfunction

  // Lowest terms by Euclid; sign moves to the numerator.
  function automatic reduced_t reduce_fraction(input logic [63:0] n_raw,
                                               input logic [63:0] d_raw);
    reduced_t    r;
    logic        n_neg;
    logic        d_neg;
    logic [63:0] nm;
    logic [63:0] dm;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    logic [63:0] rn;
    logic [63:0] rd;
    nm = term_magnitude(n_raw, n_neg);
    dm = term_magnitude(d_raw, d_neg);
    if (dm == 64'd0) begin
      r.num  = '0;
      r.den  = '0;
      r.kind = KIND_ERROR;
      return r;
    end
    a = nm;
    b = dm;
    while (b != 64'd0) begin
      t = b;
      b = a % b;
      a = t;
    end
    rn = nm / a;
    rd = dm / a;
    r.num  = (rn != 64'd0 && n_neg != d_neg) ? 64'd0 - rn : rn;
    r.den  = rd[DEN_W-1:0];
    r.kind = (rd == 64'd1) ? KIND_WHOLE : KIND_PROPER;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, exp_val);
    n_errors++;
  endtask

  function automatic bit quiet_tail();
    return pending.size() < TAIL_ITEMS;
  endfunction

  function automatic logic [63:0] with_random_sign(input logic [63:0] mag);
    return $urandom_range(0, 1) ? 64'd0 - mag : mag;
  endfunction

  task automatic queue_fraction(input logic [63:0] n, input logic [63:0] d);
    fraction_t f;
    f.num = n;
    f.den = d;
    pending.push_back(f);
  endtask

  // Input side: a word stays up until taken, then an optional burst of idle.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 3);
        s_tvalid <= 1'b0;
      end else begin
        s_tdata  <= {pending[0].den, pending[0].num};
        s_tvalid <= 1'b1;
        void'(pending.pop_front());
      end
    end
  end

  // Output side back-pressure in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else if (!quiet_tail() && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Sample both handshakes at the rising edge: predict on input, check on output.
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      reduced_q.push_back(reduce_fraction(s_tdata[63:0], s_tdata[127:64]));
      n_fed++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (reduced_q.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
      end else begin
        want = reduced_q.pop_front();
        if (m_tdata[63:0] !== want.num)
          report_mismatch("numerator", m_tdata[63:0], want.num);
        if (m_tdata[64 +: DEN_W] !== want.den)
          report_mismatch("denominator", {1'b0, m_tdata[64 +: DEN_W]}, {1'b0, want.den});
        if (m_tuser !== want.kind)
          report_mismatch("kind", {62'd0, m_tuser}, {62'd0, want.kind});
      end
    end
  end

  // Stimulus, then the end-of-run wait.
  initial begin
    int          sel;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] g;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    in_fire  = 1'b0;
    in_gap   = 0;
    out_gap  = 0;
    n_fed    = 0;
    n_errors = 0;

    // Directed: zero terms, extremes, signs, worst-case Euclid chain.
    queue_fraction(64'd0, 64'd1);
    queue_fraction(64'd0, 64'd0 - 64'd5);
    queue_fraction(64'd5, 64'd0);                  // zero denominator
    queue_fraction(64'd0, 64'd0);                  // both zero
    queue_fraction(NEG_MIN, 64'd0);
    queue_fraction(64'd0, NEG_MIN);
    queue_fraction(POS_MAX, POS_MAX);
    queue_fraction(NEG_MIN, NEG_MIN);              // saturated both sides
    queue_fraction(POS_MAX, NEG_MIN);
    queue_fraction(NEG_MIN, 64'd1);
    queue_fraction(64'd1, NEG_MIN);
    queue_fraction(POS_MAX, 64'd1);
    queue_fraction(64'd1, POS_MAX);
    queue_fraction(64'd0 - 64'd1, 64'd0 - 64'd1);
    queue_fraction(64'd6, 64'd4);
    queue_fraction(64'd0 - 64'd6, 64'd4);
    queue_fraction(64'd6, 64'd0 - 64'd4);
    queue_fraction(64'd0 - 64'd6, 64'd0 - 64'd4);
    queue_fraction(64'd12, 64'd3);
    queue_fraction(FIB_92, FIB_91);
    queue_fraction(64'd0 - FIB_91, FIB_92);
    queue_fraction(64'd1 << 62, 64'd1 << 40);
    queue_fraction(64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);

    // Random: mostly short Euclid chains, some full width.
    repeat (1380) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        g = $urandom_range(1, 50);
        a = $urandom_range(0, 1000) * g;
        b = $urandom_range(1, 1000) * g;
      end else if (sel < 50) begin
        a = $urandom();
        b = {32'd0, $urandom()} | 64'd1;
      end else if (sel < 62) begin
        g = $urandom_range(1, 32'h7FFF_FFFF);
        a = $urandom_range(0, 32'h7FFF_FFFF) * g;
        b = $urandom_range(1, 32'h7FFF_FFFF) * g;
      end else if (sel < 80) begin
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
      end else if (sel < 85) begin
        a = {$urandom(), $urandom()};
        b = 64'd0;
      end else if (sel < 90) begin
        a = 64'd0;
        b = {$urandom(), $urandom()};
      end else begin
        case ($urandom_range(0, 3))
          0: a = NEG_MIN;
          1: a = POS_MAX;
          2: a = 64'd1;
          default: a = {$urandom(), $urandom()};
        endcase
        case ($urandom_range(0, 3))
          0: b = NEG_MIN;
          1: b = POS_MAX;
          2: b = 64'd1;
          default: b = {$urandom(), $urandom()};
        endcase
      end
      if (sel < 62) begin
        a = with_random_sign(a);
        b = with_random_sign(b);
      end
      queue_fraction(a, b);
    end
    n_total = pending.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_fed < n_total) @(negedge clk);
    while (reduced_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #400_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
